### sv/avr_pkg.sv
// ============================================================================
// avr_pkg
// Shared types, constants and the sine table generator for the axis-angle
// vector rotation pipeline.
// ============================================================================
package avr_pkg;

    localparam int VEC_W       = 16;
    localparam int ANGLE_W     = 16;
    localparam int QUAD_W      = 2;
    // angle bits below the quadrant select
    localparam int ANGLE_FRAC_W = ANGLE_W - QUAD_W;
    localparam int PIPE_DEPTH  = 6;
    localparam int OUT_MAX     = 32767;
    localparam int OUT_MIN     = -32768;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [63:0] u64_t;

    typedef enum logic [QUAD_W-1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Quarter-wave sine entry k, Taylor series in Q30, rounded to frac_bits.
    // Only evaluated at elaboration.
    function automatic longint sine_entry(input int k, input int frac_bits,
                                          input int table_bits);
        u64_t   rom_last;
        u64_t   x;
        u64_t   term;
        longint sum;
        longint v;
        int     sh;
        rom_last = 64'd1 << table_bits;
        x        = (64'(k) * HALF_PI_Q30 + (rom_last >> 1)) >> table_bits;
        term     = x;
        sum      = signed'(x);
        for (int n = 1; n <= 8; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                default: term = term / 64'd272;
            endcase
            if (n[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        v  = (sum < 0) ? 64'sd0 : sum;
        sh = 30 - frac_bits;
        if (sh > 0)
            v = signed'((u64_t'(v) + (64'd1 << (sh - 1))) >> sh);
        if (v > (64'sd1 <<< frac_bits))
            v = 64'sd1 <<< frac_bits;
        return v;
    endfunction

endpackage

### sv/avr_trig.sv
// ============================================================================
// avr_trig
// Two-stage sine/cosine lookup: quarter-wave table read, then quadrant
// folding into sin, cos and (1 - cos).
// ============================================================================
module avr_trig #(
    parameter int FRAC_BITS       = 14,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [avr_pkg::ANGLE_W-1:0]   angle,
    output logic signed [FRAC_BITS+1:0]   sin_val,
    output logic signed [FRAC_BITS+1:0]   cos_val,
    output logic signed [FRAC_BITS+2:0]   omc_val
);

    localparam int TW       = FRAC_BITS + 1;
    localparam int SW       = FRAC_BITS + 2;
    localparam int OW       = FRAC_BITS + 3;
    localparam int IW       = SINE_TABLE_BITS + 1;
    localparam int ROM_LAST = 1 << SINE_TABLE_BITS;
    localparam logic signed [OW-1:0] OMC_ONE = OW'(64'd1 << FRAC_BITS);

    logic [TW-1:0] rom [ROM_LAST+1];

    for (genvar k = 0; k <= ROM_LAST; k++) begin : g_rom
        assign rom[k] = TW'(avr_pkg::sine_entry(k, FRAC_BITS, SINE_TABLE_BITS));
    end

    logic [SINE_TABLE_BITS-1:0] idx;
    logic [IW-1:0]              idx_lo;
    logic [IW-1:0]              idx_hi;
    avr_pkg::quad_t             quad;

    assign idx    = angle[avr_pkg::ANGLE_FRAC_W-1 -: SINE_TABLE_BITS];
    assign idx_lo = {1'b0, idx};
    assign idx_hi = IW'(ROM_LAST) - idx_lo;
    assign quad   = avr_pkg::quad_t'(angle[avr_pkg::ANGLE_W-1 -: avr_pkg::QUAD_W]);

    // stage 1: table read
    logic [TW-1:0]  t_lo_reg;
    logic [TW-1:0]  t_hi_reg;
    avr_pkg::quad_t q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_lo_reg <= rom[idx_lo];
            t_hi_reg <= rom[idx_hi];
            q_reg    <= quad;
        end
    end

    // stage 2: quadrant fold
    logic signed [SW-1:0] lo_s;
    logic signed [SW-1:0] hi_s;
    logic signed [SW-1:0] sin_next;
    logic signed [SW-1:0] cos_next;
    logic signed [OW-1:0] omc_next;
    logic signed [SW-1:0] sin_reg;
    logic signed [SW-1:0] cos_reg;
    logic signed [OW-1:0] omc_reg;

    always_comb
    begin
        lo_s = $signed(SW'(t_lo_reg));
        hi_s = $signed(SW'(t_hi_reg));
        case (q_reg)
            avr_pkg::QUAD_0:
            begin
                sin_next = lo_s;
                cos_next = hi_s;
            end
            avr_pkg::QUAD_1:
            begin
                sin_next = hi_s;
                cos_next = -lo_s;
            end
            avr_pkg::QUAD_2:
            begin
                sin_next = -lo_s;
                cos_next = -hi_s;
            end
            default:
            begin
                sin_next = -hi_s;
                cos_next = lo_s;
            end
        endcase
        omc_next = OMC_ONE - OW'(cos_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
            omc_reg <= omc_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;
    assign omc_val = omc_reg;

endmodule

### sv/avr_matrix.sv
// ============================================================================
// avr_matrix
// Four-stage build of the Rodrigues matrix from the axis and sin/cos:
// w*w^T, rescale, scale by (1 - cos) and w*sin, then assembly.
// ============================================================================
module avr_matrix #(
    parameter int FRAC_BITS = 14,
    parameter int M_W       = 21
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [avr_pkg::VEC_W-1:0]   axis [3],
    input  logic signed [FRAC_BITS+1:0]        sin_val,
    input  logic signed [FRAC_BITS+1:0]        cos_val,
    input  logic signed [FRAC_BITS+2:0]        omc_val,
    output logic signed [M_W-1:0]              mat [3][3]
);

    localparam int VW  = avr_pkg::VEC_W;
    localparam int SW  = FRAC_BITS + 2;
    localparam int OW  = FRAC_BITS + 3;
    localparam int WW  = 2 * VW;
    localparam int RW  = 33 - FRAC_BITS;
    localparam int PW  = RW + OW;
    localparam int WSW = VW + SW;

    localparam logic signed [WW:0]  WW_HALF = (WW+1)'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [PW:0]  P_HALF  = (PW+1)'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [WSW:0] WS_HALF = (WSW+1)'(64'd1 << (FRAC_BITS - 1));

    // the six distinct products of w*w^T: diagonal, then xy, xz, yz
    localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
    localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

    logic signed [WW-1:0]  ww_reg  [6];
    logic signed [VW-1:0]  w1_reg  [3];
    logic signed [RW-1:0]  rww_reg [6];
    logic signed [VW-1:0]  w2_reg  [3];
    logic signed [PW-1:0]  p_reg   [6];
    logic signed [WSW-1:0] wsr_reg [3];
    logic signed [SW-1:0]  c3_reg;
    logic signed [M_W-1:0] m_reg   [3][3];

    logic signed [WW-1:0]  ww_next  [6];
    logic signed [RW-1:0]  rww_next [6];
    logic signed [PW-1:0]  p_next   [6];
    logic signed [WSW-1:0] wsr_next [3];
    logic signed [M_W-1:0] m1_v     [6];
    logic signed [M_W-1:0] ws_v     [3];
    logic signed [M_W-1:0] c_v;
    logic signed [M_W-1:0] m_next   [3][3];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            ww_next[i]  = WW'(axis[PA[i]]) * WW'(axis[PB[i]]);
            rww_next[i] = RW'(((WW+1)'(ww_reg[i]) + WW_HALF) >>> FRAC_BITS);
            p_next[i]   = PW'(rww_reg[i]) * PW'(omc_val);
            m1_v[i]     = M_W'(((PW+1)'(p_reg[i]) + P_HALF) >>> FRAC_BITS);
        end
        for (int r = 0; r < 3; r++)
        begin
            wsr_next[r] = WSW'(w2_reg[r]) * WSW'(sin_val);
            ws_v[r]     = M_W'(((WSW+1)'(wsr_reg[r]) + WS_HALF) >>> FRAC_BITS);
        end
        c_v = M_W'(c3_reg);

        m_next[0][0] = m1_v[0] + c_v;
        m_next[1][1] = m1_v[1] + c_v;
        m_next[2][2] = m1_v[2] + c_v;
        // cross-product terms of the skew-symmetric part
        m_next[0][1] = m1_v[3] - ws_v[2];
        m_next[1][0] = m1_v[3] + ws_v[2];
        m_next[0][2] = m1_v[4] + ws_v[1];
        m_next[2][0] = m1_v[4] - ws_v[1];
        m_next[1][2] = m1_v[5] - ws_v[0];
        m_next[2][1] = m1_v[5] + ws_v[0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg  <= ww_next;
            w1_reg  <= axis;
            rww_reg <= rww_next;
            w2_reg  <= w1_reg;
            p_reg   <= p_next;
            wsr_reg <= wsr_next;
            c3_reg  <= cos_val;
            m_reg   <= m_next;
        end
    end

    assign mat = m_reg;

endmodule

### sv/avr_apply.sv
// ============================================================================
// avr_apply
// Two-stage matrix-vector product: nine products, then row sums with
// rounding and saturation to 16 bits.
// ============================================================================
module avr_apply #(
    parameter int FRAC_BITS = 14,
    parameter int M_W       = 21
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [M_W-1:0]              mat [3][3],
    input  logic signed [avr_pkg::VEC_W-1:0]   dir [3],
    output logic signed [avr_pkg::VEC_W-1:0]   res [3]
);

    localparam int VW  = avr_pkg::VEC_W;
    localparam int PRW = M_W + VW;
    localparam int AW  = PRW + 2;

    localparam logic signed [AW-1:0] ACC_HALF = AW'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [AW-1:0] SAT_HI   = AW'(avr_pkg::OUT_MAX);
    localparam logic signed [AW-1:0] SAT_LO   = AW'(avr_pkg::OUT_MIN);

    logic signed [PRW-1:0] prod_reg  [3][3];
    logic signed [PRW-1:0] prod_next [3][3];
    logic signed [VW-1:0]  res_reg   [3];
    logic signed [VW-1:0]  res_next  [3];
    logic signed [AW-1:0]  acc       [3];
    logic signed [AW-1:0]  rs        [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int j = 0; j < 3; j++)
                prod_next[r][j] = PRW'(mat[r][j]) * PRW'(dir[j]);
            acc[r] = AW'(prod_reg[r][0]) + AW'(prod_reg[r][1]) + AW'(prod_reg[r][2])
                     + ACC_HALF;
            rs[r]  = acc[r] >>> FRAC_BITS;
            if (rs[r] > SAT_HI)
                res_next[r] = VW'(SAT_HI);
            else if (rs[r] < SAT_LO)
                res_next[r] = VW'(SAT_LO);
            else
                res_next[r] = VW'(rs[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### sv/axis_angle_vector_rotation.sv
// ============================================================================
// axis_angle_vector_rotation
// Rotates a Q2.14 direction vector about a unit axis by a binary angle
// (Rodrigues' formula), one saturated vector out per vector in.
// ============================================================================
// Usage:
//   Input channel: in_valid / in_stall with dir_*, axis_*, angle. A beat is
//   taken on a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with out_x, out_y, out_z.
//   Throughput: one beat per cycle, sustained, while out_stall is low.
//   Pipeline: out_valid rises as the input beat leaves the last stage (six
//   register stages: table read with w*w^T, quadrant fold with rescale,
//   scaling, matrix assembly, products, row sum and saturation).
//   Stall: with a result held on the output and out_stall high the whole
//   pipeline freezes and in_stall rises in the same cycle; nothing is lost
//   or repeated. Bubbles in flight are not squeezed out.
//   Reset: rst_n clears all stage valid bits; no beat is presented until a
//   new one has passed through. The sine table is constant logic.
//   No internal state carries between beats.
// ============================================================================
module axis_angle_vector_rotation #(
    parameter int FRAC_BITS       = 14,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [avr_pkg::VEC_W-1:0]    dir_x,
    input  logic signed [avr_pkg::VEC_W-1:0]    dir_y,
    input  logic signed [avr_pkg::VEC_W-1:0]    dir_z,
    input  logic signed [avr_pkg::VEC_W-1:0]    axis_x,
    input  logic signed [avr_pkg::VEC_W-1:0]    axis_y,
    input  logic signed [avr_pkg::VEC_W-1:0]    axis_z,
    input  logic [avr_pkg::ANGLE_W-1:0]         angle,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [avr_pkg::VEC_W-1:0]    out_x,
    output logic signed [avr_pkg::VEC_W-1:0]    out_y,
    output logic signed [avr_pkg::VEC_W-1:0]    out_z
);

    localparam int VW    = avr_pkg::VEC_W;
    localparam int DEPTH = avr_pkg::PIPE_DEPTH;
    // matrix entry magnitude bound: max(31 - F, F) plus headroom
    localparam int MAG_B = (31 - FRAC_BITS > FRAC_BITS) ? (31 - FRAC_BITS) : FRAC_BITS;
    localparam int M_W   = MAG_B + 4;
    // direction is consumed by the product stage, after four stages
    localparam int D_DLY = 4;

    logic                 adv;
    logic [DEPTH-1:0]     v_reg;
    logic [DEPTH-1:0]     v_next;

    logic signed [VW-1:0]          dir_in  [3];
    logic signed [VW-1:0]          axis_in [3];
    logic signed [VW-1:0]          d_reg   [D_DLY][3];
    logic signed [FRAC_BITS+1:0]   sin_val;
    logic signed [FRAC_BITS+1:0]   cos_val;
    logic signed [FRAC_BITS+2:0]   omc_val;
    logic signed [M_W-1:0]         mat     [3][3];
    logic signed [VW-1:0]          res     [3];

    assign dir_in  = '{dir_x, dir_y, dir_z};
    assign axis_in = '{axis_x, axis_y, axis_z};

    // whole pipe moves unless the output beat is held
    assign adv      = !(v_reg[DEPTH-1] && out_stall);
    assign in_stall = !adv;
    assign v_next   = {v_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0] <= dir_in;
            for (int k = 1; k < D_DLY; k++)
                d_reg[k] <= d_reg[k-1];
        end
    end

    avr_trig #(
        .FRAC_BITS       (FRAC_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_trig (
        .clk     (clk),
        .en      (adv),
        .angle   (angle),
        .sin_val (sin_val),
        .cos_val (cos_val),
        .omc_val (omc_val)
    );

    avr_matrix #(
        .FRAC_BITS (FRAC_BITS),
        .M_W       (M_W)
    ) u_matrix (
        .clk     (clk),
        .en      (adv),
        .axis    (axis_in),
        .sin_val (sin_val),
        .cos_val (cos_val),
        .omc_val (omc_val),
        .mat     (mat)
    );

    avr_apply #(
        .FRAC_BITS (FRAC_BITS),
        .M_W       (M_W)
    ) u_apply (
        .clk (clk),
        .en  (adv),
        .mat (mat),
        .dir (d_reg[D_DLY-1]),
        .res (res)
    );

    assign out_valid = v_reg[DEPTH-1];
    assign out_x     = res[0];
    assign out_y     = res[1];
    assign out_z     = res[2];

endmodule
